// ===== hw/rtl/mpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpd_pkg: shared types and mask table for the bus packet decoder
// Mask text, character helpers and the packet tracker state struct.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int NumMasks   = 37;
  localparam int MaskChars  = 15;
  localparam int StoreDepth = 16;
  localparam int StoreIdxW  = 4;
  localparam logic [5:0] CmdInvalid = 6'd37;

  // Mask text, right justified ASCII; placeholders are lowercase letters.
  localparam logic [8*MaskChars-1:0] MaskText [NumMasks] = '{
    "18", "98", "9F0000f",
    "991ttiimmssff0f", "992ttiimmssff0f", "993ttiimmssff0f",
    "994ttiimmssff0f", "995ttiimmssff0f", "996ttiimmssff0f",
    "997ttiimmssff0f",
    "11101", "11102", "11140", "11150", "11105",
    "11109", "11106", "1110A", "11181", "11182",
    "113dttff",
    "11400000", "11440000", "11480000", "11408000", "11402000",
    "9A0000000000",
    "9B0dttfff0f", "9B8d00fff0f", "9B9dttfff0f", "9BAd00f00ff",
    "9BBd00fff0f", "9BCd00fff0f", "9BDd00fff0f",
    "9Cd01ttmmssf", "9D000fffff", "9E0000000"
  };

  typedef struct packed {
    logic [StoreDepth-1:0][3:0] store;
    logic [3:0]                 xor_sum;
    logic [NumMasks-1:0]        match;
  } pkt_t;

  typedef struct packed {
    logic [3:0]  source;
    logic [3:0]  computed_checksum;
    logic        checksum_ok;
    logic [5:0]  command;
    logic [5:0]  content;
    logic [2:0]  flag_digits;
    logic [3:0]  disk;
    logic [7:0]  track;
    logic [7:0]  track_index;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [19:0] flags;
  } res_t;

  function automatic int mask_len(input int m);
    int n;
    n = 0;
    for (int p = 0; p < MaskChars; p++) begin
      if (MaskText[m][p*8 +: 8] != 8'h00) n++;
    end
    return n;
  endfunction

  // Character at position p, counted from the first digit on the bus.
  function automatic logic [7:0] mask_char(input int m, input int p);
    int n;
    n = mask_len(m);
    if (p >= n) return 8'h00;
    return MaskText[m][(n-1-p)*8 +: 8];
  endfunction

  function automatic logic is_literal(input logic [7:0] c);
    return ((c >= "0") && (c <= "9")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [3:0] literal_value(input logic [7:0] c);
    logic [7:0] v;
    v = (c <= "9") ? (c - "0") : (c - "A" + 8'd10);
    return v[3:0];
  endfunction

endpackage

// ===== hw/rtl/mpd_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpd_match: packet tracker
// Buffers nibbles, keeps the running XOR and per-mask literal match bits.
// ----------------------------------------------------------------------------
module mpd_match #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 accept_i,
  input  logic [3:0]                           nibble_i,
  input  logic                                 last_i,
  output mpd_pkg::pkt_t                        pkt_o,
  output logic [$clog2(MAX_DIGITS+1)-1:0]      count_o
);
  localparam int CntW = $clog2(MAX_DIGITS + 1);

  logic [CntW-1:0]                        cnt_q;
  logic [3:0]                             xor_q;
  logic [mpd_pkg::NumMasks-1:0]           match_q, keep;
  logic [mpd_pkg::StoreDepth-1:0][3:0]    store_q;

  // clear a mask's bit when its literal at the current position differs
  always_comb begin
    logic [7:0] c;
    keep = '1;
    for (int i = 0; i < mpd_pkg::NumMasks; i++) begin
      for (int p = 0; p < mpd_pkg::MaskChars; p++) begin
        c = mpd_pkg::mask_char(i, p);
        if ((cnt_q == CntW'(p)) && mpd_pkg::is_literal(c) &&
            (mpd_pkg::literal_value(c) != nibble_i)) begin
          keep[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      xor_q   <= '0;
      match_q <= '1;
    end else if (accept_i) begin
      if (last_i) begin
        cnt_q   <= '0;
        xor_q   <= '0;
        match_q <= '1;
      end else begin
        if (cnt_q < CntW'(MAX_DIGITS)) cnt_q <= cnt_q + 1'b1;
        xor_q   <= xor_q ^ nibble_i;
        match_q <= match_q & keep;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !last_i && (cnt_q < CntW'(mpd_pkg::StoreDepth))) begin
      store_q[cnt_q[mpd_pkg::StoreIdxW-1:0]] <= nibble_i;
    end
  end

  assign pkt_o.store   = store_q;
  assign pkt_o.xor_sum = xor_q;
  assign pkt_o.match   = match_q;
  assign count_o       = cnt_q;

endmodule

// ===== hw/rtl/mpd_gather.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpd_gather: command select and field gather
// Picks the first mask whose literals and length match, collects its fields.
// ----------------------------------------------------------------------------
module mpd_gather #(
  parameter int MAX_DIGITS = 16
) (
  input  mpd_pkg::pkt_t                        pkt_i,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]      count_i,
  input  logic [3:0]                           nibble_i,
  output mpd_pkg::res_t                        res_o
);
  localparam int CntW = $clog2(MAX_DIGITS + 1);

  always_comb begin
    logic       found;
    logic [3:0] d;
    logic [3:0] chk;
    found = 1'b0;
    res_o = '0;
    res_o.command = mpd_pkg::CmdInvalid;
    chk = pkt_i.xor_sum + 4'd1;
    d = '0;
    if (count_i >= CntW'(2)) begin
      res_o.source            = pkt_i.store[0];
      res_o.computed_checksum = chk;
      res_o.checksum_ok       = (chk == nibble_i);
      for (int i = 0; i < mpd_pkg::NumMasks; i++) begin
        if (!found && pkt_i.match[i] &&
            (count_i == CntW'(mpd_pkg::mask_len(i)))) begin
          found = 1'b1;
          res_o.command = 6'(i);
          for (int p = 0; p < mpd_pkg::MaskChars; p++) begin
            d = pkt_i.store[p];
            unique case (mpd_pkg::mask_char(i, p))
              "d": begin
                res_o.disk = d;
                res_o.content[0] = 1'b1;
              end
              "t": begin
                res_o.track = {res_o.track[3:0], d};
                res_o.content[1] = 1'b1;
              end
              "i": begin
                res_o.track_index = {res_o.track_index[3:0], d};
                res_o.content[2] = 1'b1;
              end
              "m": begin
                res_o.minute = {res_o.minute[3:0], d};
                res_o.content[3] = 1'b1;
              end
              "s": begin
                res_o.second = {res_o.second[3:0], d};
                res_o.content[4] = 1'b1;
              end
              "f": begin
                res_o.flags = {res_o.flags[15:0], d};
                res_o.content[5] = 1'b1;
                res_o.flag_digits = res_o.flag_digits + 3'd1;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/mbus_packet_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbus_packet_decoder_core: CD-changer bus packet decoder
// Decodes a packet delivered one hex nibble per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one nibble per
//   transaction; last_i marks the checksum nibble that closes a packet.
//   Output channel (out_valid_o / out_ready_i) carries one decoded result
//   per packet, issued for the transaction that had last_i set.
//   Latency: the result is valid the cycle after the checksum nibble is
//   accepted. Throughput: one nibble per cycle while in_ready_o is high,
//   set by the per-nibble update of the mask match bits and the single result register.
//   The result register frees in the same cycle it is taken, so nibbles
//   keep flowing while a result waits; in_ready_o drops only when a
//   result is held and out_ready_i is low.
//   Reset clears the nibble count, running XOR, match bits and the
//   output valid; the nibble buffer is not cleared (never read unwritten).
//   Packets shorter than three nibbles, or matching no mask, report the
//   invalid command. Nibbles past MAX_DIGITS still enter the checksum.
// ----------------------------------------------------------------------------
module mbus_packet_decoder_core #(
  parameter int MAX_DIGITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  nibble_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  source_o,
  output logic [3:0]  computed_checksum_o,
  output logic        checksum_ok_o,
  output logic [5:0]  command_o,
  output logic [5:0]  content_o,
  output logic [2:0]  flag_digits_o,
  output logic [3:0]  disk_o,
  output logic [7:0]  track_o,
  output logic [7:0]  track_index_o,
  output logic [7:0]  minute_o,
  output logic [7:0]  second_o,
  output logic [19:0] flags_o
);
  localparam int CntW = $clog2(MAX_DIGITS + 1);

  logic          accept;
  mpd_pkg::pkt_t pkt;
  logic [CntW-1:0] count;
  mpd_pkg::res_t res_d, res_q;
  logic          out_valid_q;

  // output register drains in the cycle it is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  mpd_match #(.MAX_DIGITS(MAX_DIGITS)) u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .nibble_i (nibble_i),
    .last_i   (last_i),
    .pkt_o    (pkt),
    .count_o  (count)
  );

  mpd_gather #(.MAX_DIGITS(MAX_DIGITS)) u_gather (
    .pkt_i    (pkt),
    .count_i  (count),
    .nibble_i (nibble_i),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload only loads on a closing nibble
  always_ff @(posedge clk_i) begin
    if (accept && last_i) res_q <= res_d;
  end

  assign out_valid_o         = out_valid_q;
  assign source_o            = res_q.source;
  assign computed_checksum_o = res_q.computed_checksum;
  assign checksum_ok_o       = res_q.checksum_ok;
  assign command_o           = res_q.command;
  assign content_o           = res_q.content;
  assign flag_digits_o       = res_q.flag_digits;
  assign disk_o              = res_q.disk;
  assign track_o             = res_q.track;
  assign track_index_o       = res_q.track_index;
  assign minute_o            = res_q.minute;
  assign second_o            = res_q.second;
  assign flags_o             = res_q.flags;

endmodule
